// ===== rtl/clst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clst_pkg
// Types and constants shared by the call latency statistics table.
// ----------------------------------------------------------------------------
package clst_pkg;

    localparam int CNT_W = 7;

    localparam logic [2:0] OP_RECORD_OK  = 3'd0;
    localparam logic [2:0] OP_RECORD_ERR = 3'd1;
    localparam logic [2:0] OP_READ_ONE   = 3'd2;
    localparam logic [2:0] OP_READ_ALL   = 3'd3;
    localparam logic [2:0] OP_CLEAR_ONE  = 3'd4;
    localparam logic [2:0] OP_CLEAR_ALL  = 3'd5;

    localparam logic STS_OK        = 1'b0;
    localparam logic STS_BAD_INDEX = 1'b1;

    typedef enum logic [1:0] {
        K_NONE,
        K_BLANK,
        K_RMW,
        K_WALK
    } t_kind;

    typedef struct packed {
        logic [63:0]        call_count;
        logic [63:0]        fail_count;
        logic [63:0]        time_sum;
        logic [63:0]        time_max;
        logic [63:0]        time_min;
        logic signed [31:0] fail_code;
        logic [62:0]        fail_time;
    } t_entry;

    typedef struct packed {
        logic load;
        logic update;
        logic step;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  walk_last;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/call_latency_stats_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// call_latency_stats_table
// Per-call-site statistics table: counts, time total, extremes and the
// latest failure of each entry, updated and read one item at a time.
// ----------------------------------------------------------------------------
// Record, read one and clear one read the entry from the entry memory in
// the accept cycle and write it back with the result registered in the
// next; busy is high for that one cycle.
// Out-of-range items and clear all give their result in the cycle after accept.
// Read all gives one result per cycle over n entries.
// Reset marks every entry empty at once; results are never held off.
module call_latency_stats_table #(
    parameter int NUM_ENTRIES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_op,
    input  wire logic [5:0]         i_entry_index,
    input  wire logic [63:0]        i_run_time,
    input  wire logic signed [31:0] i_err_code,
    input  wire logic [62:0]        i_now_time,
    input  wire logic [6:0]         i_read_count,
    output logic                    o_valid,
    output logic                    o_status,
    output logic [5:0]              o_slot,
    output logic [63:0]             o_call_count,
    output logic [63:0]             o_fail_count,
    output logic [63:0]             o_time_sum,
    output logic [63:0]             o_time_max,
    output logic [63:0]             o_time_min,
    output logic signed [31:0]      o_last_fail_code,
    output logic [62:0]             o_last_fail_time,
    output logic                    o_last
);

    clst_pkg::t_cmd cmd;
    clst_pkg::t_sts sts;

    clst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    clst_dp #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_op             (i_op),
        .i_entry_index    (i_entry_index),
        .i_run_time       (i_run_time),
        .i_err_code       (i_err_code),
        .i_now_time       (i_now_time),
        .i_read_count     (i_read_count),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_call_count     (o_call_count),
        .o_fail_count     (o_fail_count),
        .o_time_sum       (o_time_sum),
        .o_time_max       (o_time_max),
        .o_time_min       (o_time_min),
        .o_last_fail_code (o_last_fail_code),
        .o_last_fail_time (o_last_fail_time),
        .o_last           (o_last)
    );

endmodule
`default_nettype wire

// ===== rtl/clst_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clst_ctrl
// Sequencer: accepts items and steps the datapath through an entry update
// or a walk over the table.
// ----------------------------------------------------------------------------
module clst_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire clst_pkg::t_sts  i_sts,
    output clst_pkg::t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_WALK
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && start;
        o_cmd.update = (r_state == S_UPDATE);
        o_cmd.step   = (r_state == S_WALK);
    end

    assign busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (i_sts.kind)
                            clst_pkg::K_RMW: begin
                                r_state <= S_UPDATE;
                                r_busy  <= 1'b1;
                            end
                            clst_pkg::K_WALK: begin
                                r_state <= S_WALK;
                                r_busy  <= 1'b1;
                            end
                            default: begin
                                r_state <= S_IDLE;
                                r_busy  <= 1'b0;
                            end
                        endcase
                    end
                end
                S_UPDATE: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                S_WALK: begin
                    if (i_sts.walk_last) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/clst_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// clst_dp
// Datapath: entry memory with per-entry valid bits, update logic and the
// registered result outputs.
// ----------------------------------------------------------------------------
module clst_dp #(
    parameter int NUM_ENTRIES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire clst_pkg::t_cmd     i_cmd,
    output clst_pkg::t_sts          o_sts,
    input  wire logic [2:0]         i_op,
    input  wire logic [5:0]         i_entry_index,
    input  wire logic [63:0]        i_run_time,
    input  wire logic signed [31:0] i_err_code,
    input  wire logic [62:0]        i_now_time,
    input  wire logic [6:0]         i_read_count,
    output logic                    o_valid,
    output logic                    o_status,
    output logic [5:0]              o_slot,
    output logic [63:0]             o_call_count,
    output logic [63:0]             o_fail_count,
    output logic [63:0]             o_time_sum,
    output logic [63:0]             o_time_max,
    output logic [63:0]             o_time_min,
    output logic signed [31:0]      o_last_fail_code,
    output logic [62:0]             o_last_fail_time,
    output logic                    o_last
);

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW = clst_pkg::CNT_W;
    localparam logic [CW-1:0] NUM_E = CW'(NUM_ENTRIES);

    clst_pkg::t_entry r_mem [NUM_ENTRIES];
    clst_pkg::t_entry r_rdata;
    logic             r_rvalid;
    logic [NUM_ENTRIES-1:0] r_valid;

    logic [2:0]         r_op;
    logic [IW-1:0]      r_idx;
    logic [63:0]        r_time;
    logic signed [31:0] r_code;
    logic [62:0]        r_stamp;
    logic [CW-1:0]      r_rem;
    logic [IW-1:0]      r_ptr;

    logic                       r_oval;
    logic                       r_ostatus;
    logic [5:0]                 r_oslot;
    clst_pkg::t_entry           r_oentry;
    logic                       r_olast;

    logic                       entry_op;
    logic                       in_range;
    logic [CW-1:0]              n_want;
    clst_pkg::t_kind            kind;
    logic [IW-1:0]              rd_addr;
    logic                       rd_en;
    clst_pkg::t_entry           cur;
    clst_pkg::t_entry           n_entry;
    logic                       walk_last;

    assign entry_op = (i_op == clst_pkg::OP_RECORD_OK) || (i_op == clst_pkg::OP_RECORD_ERR)
                   || (i_op == clst_pkg::OP_READ_ONE) || (i_op == clst_pkg::OP_CLEAR_ONE);
    assign in_range = {1'b0, i_entry_index} < NUM_E;
    assign n_want   = (i_read_count < NUM_E) ? i_read_count : NUM_E;

    always_comb begin
        kind = clst_pkg::K_NONE;
        if (entry_op) begin
            kind = in_range ? clst_pkg::K_RMW : clst_pkg::K_BLANK;
        end else if (i_op == clst_pkg::OP_CLEAR_ALL) begin
            kind = clst_pkg::K_BLANK;
        end else if ((i_op == clst_pkg::OP_READ_ALL) && (n_want != '0)) begin
            kind = clst_pkg::K_WALK;
        end
    end

    assign walk_last       = (r_rem == CW'(1));
    assign o_sts.kind      = kind;
    assign o_sts.walk_last = walk_last;

    always_comb begin
        if (i_cmd.load) begin
            rd_addr = (i_op == clst_pkg::OP_READ_ALL) ? '0 : i_entry_index[IW-1:0];
            rd_en   = (kind == clst_pkg::K_RMW) || (kind == clst_pkg::K_WALK);
        end else begin
            rd_addr = r_ptr + IW'(1);
            rd_en   = i_cmd.step && !walk_last;
        end
    end

    assign cur = r_rvalid ? r_rdata : '0;

    always_comb begin
        n_entry = cur;
        case (r_op)
            clst_pkg::OP_RECORD_OK: begin
                n_entry.call_count = cur.call_count + 64'd1;
                n_entry.time_sum   = cur.time_sum + r_time;
                if (r_time > cur.time_max) begin
                    n_entry.time_max = r_time;
                end
                if ((r_time < cur.time_min) || (cur.time_min == '0)) begin
                    n_entry.time_min = r_time;
                end
            end
            clst_pkg::OP_RECORD_ERR: begin
                n_entry.fail_count = cur.fail_count + 64'd1;
                n_entry.fail_code  = r_code;
                n_entry.fail_time  = r_stamp;
            end
            clst_pkg::OP_CLEAR_ONE: begin
                n_entry = '0;
            end
            default: begin
                n_entry = cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_mem[r_idx] <= n_entry;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
            r_oval   <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rvalid <= r_valid[rd_addr];
            end
            if (i_cmd.load && (i_op == clst_pkg::OP_CLEAR_ALL)) begin
                r_valid <= '0;
            end else if (i_cmd.update) begin
                r_valid[r_idx] <= 1'b1;
            end
            r_oval <= (i_cmd.load && (kind == clst_pkg::K_BLANK))
                   || i_cmd.update || i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_idx   <= i_entry_index[IW-1:0];
            r_time  <= i_run_time;
            r_code  <= i_err_code;
            r_stamp <= i_now_time;
            r_rem   <= n_want;
            r_ptr   <= '0;
            r_ostatus <= (i_op == clst_pkg::OP_CLEAR_ALL) ? clst_pkg::STS_OK
                                                          : clst_pkg::STS_BAD_INDEX;
            r_oslot   <= (i_op == clst_pkg::OP_CLEAR_ALL) ? '0 : i_entry_index;
            r_oentry  <= '0;
            r_olast   <= 1'b1;
        end else if (i_cmd.update) begin
            r_ostatus <= clst_pkg::STS_OK;
            r_oslot   <= 6'(r_idx);
            r_oentry  <= n_entry;
            r_olast   <= 1'b1;
        end else if (i_cmd.step) begin
            r_ostatus <= clst_pkg::STS_OK;
            r_oslot   <= 6'(r_ptr);
            r_oentry  <= cur;
            r_olast   <= walk_last;
            r_rem     <= r_rem - CW'(1);
            r_ptr     <= r_ptr + IW'(1);
        end
    end

    assign o_valid          = r_oval;
    assign o_status         = r_ostatus;
    assign o_slot           = r_oslot;
    assign o_call_count     = r_oentry.call_count;
    assign o_fail_count     = r_oentry.fail_count;
    assign o_time_sum       = r_oentry.time_sum;
    assign o_time_max       = r_oentry.time_max;
    assign o_time_min       = r_oentry.time_min;
    assign o_last_fail_code = r_oentry.fail_code;
    assign o_last_fail_time = r_oentry.fail_time;
    assign o_last           = r_olast;

endmodule
`default_nettype wire

// ===== test/call_latency_stats_table_tb.sv =====
// ----------------------------------------------------------------------------
// call_latency_stats_table_tb
// Self-checking bench for the call latency statistics table. A queue of
// items (a directed opening, then weighted random traffic) feeds a clocked
// driver. Each accepted item updates a local copy of the table, which
// predicts the results. A clocked monitor compares each result strobe,
// field by field, with the oldest prediction. A watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module call_latency_stats_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ENTRIES = 32;
    localparam int TOTAL_ITEMS = 280;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 80;

    localparam logic [2:0] OP_UNDEF_6 = 3'd6;
    localparam logic [2:0] OP_UNDEF_7 = 3'd7;

    localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] STAMP_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [2:0]         op;
        logic [5:0]         index;
        logic [63:0]        run_time;
        logic signed [31:0] err_code;
        logic [62:0]        now_time;
        logic [6:0]         read_count;
    } t_stat_item;

    typedef struct {
        logic              status;
        logic [5:0]        slot;
        clst_pkg::t_entry  data;
        logic              last;
    } t_stat_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_op = '0;
    logic [5:0]         i_entry_index = '0;
    logic [63:0]        i_run_time = '0;
    logic signed [31:0] i_err_code = '0;
    logic [62:0]        i_now_time = '0;
    logic [6:0]         i_read_count = '0;
    logic               o_valid;
    logic               o_status;
    logic [5:0]         o_slot;
    logic [63:0]        o_call_count;
    logic [63:0]        o_fail_count;
    logic [63:0]        o_time_sum;
    logic [63:0]        o_time_max;
    logic [63:0]        o_time_min;
    logic signed [31:0] o_last_fail_code;
    logic [62:0]        o_last_fail_time;
    logic               o_last;

    clst_pkg::t_entry stat_table [NUM_ENTRIES];
    t_stat_item       pending_items [$];
    t_stat_result     expected_results [$];
    t_stat_item       cur_item;
    t_stat_result     exp_res;
    int               total_items = 0;
    int               sent_count = 0;
    int               accepted_count = 0;
    int               idle_pct = 0;
    int               idle_cycles = 0;
    int               error_count = 0;

    call_latency_stats_table #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_entry_index(i_entry_index),
        .i_run_time(i_run_time),
        .i_err_code(i_err_code),
        .i_now_time(i_now_time),
        .i_read_count(i_read_count),
        .o_valid(o_valid),
        .o_status(o_status),
        .o_slot(o_slot),
        .o_call_count(o_call_count),
        .o_fail_count(o_fail_count),
        .o_time_sum(o_time_sum),
        .o_time_max(o_time_max),
        .o_time_min(o_time_min),
        .o_last_fail_code(o_last_fail_code),
        .o_last_fail_time(o_last_fail_time),
        .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_stat_item make_item(logic [2:0] op, logic [5:0] index,
                                             logic [63:0] t, logic signed [31:0] code,
                                             logic [62:0] stamp, logic [6:0] cnt);
        t_stat_item it;
        it.op = op;
        it.index = index;
        it.run_time = t;
        it.err_code = code;
        it.now_time = stamp;
        it.read_count = cnt;
        return it;
    endfunction

    function automatic t_stat_item random_item();
        t_stat_item it;
        int r;
        int s;
        logic [63:0] wide;
        r = $urandom_range(99);
        if (r < 3) it.op = ($urandom_range(1) != 0) ? OP_UNDEF_7 : OP_UNDEF_6;
        else if (r < 6) it.op = clst_pkg::OP_CLEAR_ALL;
        else if (r < 14) it.op = clst_pkg::OP_READ_ALL;
        else if (r < 50) it.op = clst_pkg::OP_RECORD_OK;
        else if (r < 72) it.op = clst_pkg::OP_RECORD_ERR;
        else if (r < 92) it.op = clst_pkg::OP_READ_ONE;
        else it.op = clst_pkg::OP_CLEAR_ONE;
        s = $urandom_range(99);
        if (s < 45) it.index = 6'($urandom_range(3));
        else if (s < 85) it.index = 6'($urandom_range(NUM_ENTRIES - 1));
        else it.index = 6'($urandom_range(63));
        s = $urandom_range(99);
        if (s < 10) it.run_time = '0;
        else if (s < 60) it.run_time = 64'($urandom_range(1000, 1));
        else if (s < 80) it.run_time = {$urandom, $urandom};
        else if (s < 90) it.run_time = T_MAX - 64'($urandom_range(3));
        else it.run_time = {32'h0, $urandom};
        it.err_code = $urandom;
        wide = {$urandom, $urandom};
        it.now_time = wide[62:0];
        s = $urandom_range(99);
        if (s < 60) it.read_count = 7'($urandom_range(4));
        else if (s < 80) it.read_count = 7'($urandom_range(40, 5));
        else it.read_count = 7'($urandom_range(127));
        return it;
    endfunction

    task automatic push_entry(int e, logic is_last);
        t_stat_result res;
        res.status = clst_pkg::STS_OK;
        res.slot = e[5:0];
        res.data = stat_table[e];
        res.last = is_last;
        expected_results.push_back(res);
    endtask

    task automatic push_blank(logic status, logic [5:0] slot);
        t_stat_result res;
        res.status = status;
        res.slot = slot;
        res.data = '0;
        res.last = 1'b1;
        expected_results.push_back(res);
    endtask

    task automatic apply_stat_op(t_stat_item it);
        int idx;
        int n;
        idx = it.index;
        case (it.op)
            clst_pkg::OP_RECORD_OK, clst_pkg::OP_RECORD_ERR,
            clst_pkg::OP_READ_ONE, clst_pkg::OP_CLEAR_ONE: begin
                if (idx >= NUM_ENTRIES) begin
                    push_blank(clst_pkg::STS_BAD_INDEX, it.index);
                end else begin
                    if (it.op == clst_pkg::OP_RECORD_OK) begin
                        stat_table[idx].call_count = stat_table[idx].call_count + 64'd1;
                        stat_table[idx].time_sum = stat_table[idx].time_sum + it.run_time;
                        if (it.run_time > stat_table[idx].time_max)
                            stat_table[idx].time_max = it.run_time;
                        if (it.run_time < stat_table[idx].time_min ||
                            stat_table[idx].time_min == 64'd0)
                            stat_table[idx].time_min = it.run_time;
                    end else if (it.op == clst_pkg::OP_RECORD_ERR) begin
                        stat_table[idx].fail_count = stat_table[idx].fail_count + 64'd1;
                        stat_table[idx].fail_code = it.err_code;
                        stat_table[idx].fail_time = it.now_time;
                    end else if (it.op == clst_pkg::OP_CLEAR_ONE) begin
                        stat_table[idx] = '0;
                    end
                    push_entry(idx, 1'b1);
                end
            end
            clst_pkg::OP_READ_ALL: begin
                n = (it.read_count < NUM_ENTRIES) ? it.read_count : NUM_ENTRIES;
                for (int e = 0; e < n; e++) push_entry(e, e + 1 == n);
            end
            clst_pkg::OP_CLEAR_ALL: begin
                for (int e = 0; e < NUM_ENTRIES; e++) stat_table[e] = '0;
                push_blank(clst_pkg::STS_OK, 6'd0);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_stat_op(cur_item);
                accepted_count++;
            end
            if (!(start && busy)) begin
                if (sent_count < total_items / 3) idle_pct = 9;
                else if (sent_count < 2 * total_items / 3) idle_pct = 62;
                else idle_pct = 0;
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    cur_item = pending_items.pop_front();
                    sent_count++;
                    i_op <= cur_item.op;
                    i_entry_index <= cur_item.index;
                    i_run_time <= cur_item.run_time;
                    i_err_code <= cur_item.err_code;
                    i_now_time <= cur_item.now_time;
                    i_read_count <= cur_item.read_count;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
                $display("%0t mismatch: expected no result, actual slot %h, status %h",
                         $time, o_slot, o_status);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                check_field("status", 64'(exp_res.status), 64'(o_status));
                check_field("slot", 64'(exp_res.slot), 64'(o_slot));
                check_field("call_count", exp_res.data.call_count, o_call_count);
                check_field("fail_count", exp_res.data.fail_count, o_fail_count);
                check_field("time_sum", exp_res.data.time_sum, o_time_sum);
                check_field("time_max", exp_res.data.time_max, o_time_max);
                check_field("time_min", exp_res.data.time_min, o_time_min);
                check_field("last_fail_code", 64'(exp_res.data.fail_code),
                            64'(o_last_fail_code));
                check_field("last_fail_time", 64'(exp_res.data.fail_time),
                            64'(o_last_fail_time));
                check_field("last", 64'(exp_res.last), 64'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t timeout: nothing accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        for (int e = 0; e < NUM_ENTRIES; e++) stat_table[e] = '0;

        pending_items.push_back(make_item(clst_pkg::OP_READ_ONE, 6'd0, '0, '0, '0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_RECORD_OK, 6'd0, 64'd0, '0, '0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_RECORD_OK, 6'd0, T_MAX, '0, '0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_RECORD_OK, 6'd0, 64'd5, '0, '0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_RECORD_OK, 6'd0, T_MAX, '0, '0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_RECORD_ERR, 6'd31, '0,
                                          32'sh8000_0000, STAMP_MAX, '0));
        pending_items.push_back(make_item(clst_pkg::OP_RECORD_ERR, 6'd31, '0,
                                          32'sh7FFF_FFFF, 63'd0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_RECORD_OK, 6'd31, 64'd1, '0, '0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_RECORD_OK, 6'd32, T_MAX, '0, '0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_RECORD_ERR, 6'd63, '0, -32'sd1,
                                          STAMP_MAX, '0));
        pending_items.push_back(make_item(clst_pkg::OP_READ_ONE, 6'd32, '0, '0, '0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_CLEAR_ONE, 6'd63, '0, '0, '0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_READ_ALL, 6'd0, '0, '0, '0, 7'd0));
        pending_items.push_back(make_item(clst_pkg::OP_READ_ALL, 6'd0, '0, '0, '0, 7'd1));
        pending_items.push_back(make_item(clst_pkg::OP_READ_ALL, 6'd0, '0, '0, '0, 7'd64));
        pending_items.push_back(make_item(clst_pkg::OP_READ_ALL, 6'd63, T_MAX, -32'sd1,
                                          STAMP_MAX, 7'd127));
        pending_items.push_back(make_item(OP_UNDEF_6, 6'd0, T_MAX, '0, '0, '0));
        pending_items.push_back(make_item(OP_UNDEF_7, 6'd31, '0, -32'sd1, STAMP_MAX, 7'd3));
        pending_items.push_back(make_item(clst_pkg::OP_CLEAR_ONE, 6'd0, '0, '0, '0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_READ_ONE, 6'd0, '0, '0, '0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_CLEAR_ALL, 6'd0, '0, '0, '0, '0));
        pending_items.push_back(make_item(clst_pkg::OP_READ_ALL, 6'd0, '0, '0, '0, 7'd32));

        while (pending_items.size() < TOTAL_ITEMS) pending_items.push_back(random_item());
        total_items = pending_items.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
